/* src/point_in_polygon_test_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for point_in_polygon_test
// Implication checks on i_clk, disabled while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef POINT_IN_POLYGON_TEST_ASSERT_SVH
`define POINT_IN_POLYGON_TEST_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define PIP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
// next-cycle implication
`define PIP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define PIP_ASSERT_IMP(lbl, ante, cons)
`define PIP_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

/* src/pip_pkg.sv */
// ---------------------------------------------------------------------------
// pip_pkg
// Shared types and constants of the point-in-polygon tester.
// ---------------------------------------------------------------------------
package pip_pkg;

    localparam int PIP_MAX_VERTICES = 64;
    localparam int PIP_COORD_BITS   = 16;
    localparam int PIP_SLOT_BITS    = 6;
    localparam int PIP_CNT_BITS     = 7;

    localparam logic [PIP_CNT_BITS-1:0] PIP_VCOUNT_RST = PIP_CNT_BITS'(3);

    // action codes
    localparam logic PIP_ACT_WRITE = 1'b0;
    localparam logic PIP_ACT_QUERY = 1'b1;

    // per-cell control
    typedef struct packed {
        logic shift;   // take the neighbor's vertex
        logic load;    // take the write beat's vertex
    } t_cell_ctl;

endpackage

/* src/pip_cell.sv */
// ---------------------------------------------------------------------------
// pip_cell
// One vertex register of the ring; loads on write, rotates during a query.
// ---------------------------------------------------------------------------
module pip_cell
    import pip_pkg::*;
#(
    parameter int COORD_BITS = PIP_COORD_BITS
) (
    input  logic                         i_clk,
    input  t_cell_ctl                    i_ctl,
    input  logic signed [COORD_BITS-1:0] i_load_x,
    input  logic signed [COORD_BITS-1:0] i_load_y,
    input  logic signed [COORD_BITS-1:0] i_next_x,
    input  logic signed [COORD_BITS-1:0] i_next_y,
    output logic signed [COORD_BITS-1:0] o_x,
    output logic signed [COORD_BITS-1:0] o_y
);

    logic signed [COORD_BITS-1:0] r_x;
    logic signed [COORD_BITS-1:0] r_y;

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_x <= i_next_x;
            r_y <= i_next_y;
        end else if (i_ctl.load) begin
            r_x <= i_load_x;
            r_y <= i_load_y;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;

endmodule

/* src/pip_edge.sv */
// ---------------------------------------------------------------------------
// pip_edge
// Three-stage edge evaluator: boundary test and ray-crossing parity.
// ---------------------------------------------------------------------------
module pip_edge
    import pip_pkg::*;
#(
    parameter int COORD_BITS = PIP_COORD_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic                         i_issue,
    input  logic signed [COORD_BITS-1:0] i_ax,
    input  logic signed [COORD_BITS-1:0] i_ay,
    input  logic signed [COORD_BITS-1:0] i_bx,
    input  logic signed [COORD_BITS-1:0] i_by,
    input  logic signed [COORD_BITS-1:0] i_px,
    input  logic signed [COORD_BITS-1:0] i_py,
    output logic                         o_edge,
    output logic                         o_par
);

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;

    // stage 1: differences and range flags
    logic                 r1_vld;
    logic signed [DW-1:0] r1_dxab, r1_dyp, r1_dxp, r1_dyab;
    logic                 r1_box, r1_strad, r1_dypos;
    // stage 2: products
    logic                 r2_vld;
    logic signed [PW-1:0] r2_p1, r2_p2;
    logic                 r2_box, r2_strad, r2_dypos;
    // accumulators
    logic                 r_edge, r_par;

    logic w_box, w_strad, w_cross;

    assign w_box = ((i_px >= i_ax && i_px <= i_bx) || (i_px >= i_bx && i_px <= i_ax)) &&
                   ((i_py >= i_ay && i_py <= i_by) || (i_py >= i_by && i_py <= i_ay));
    // half-open y range: lower end in, upper end out
    assign w_strad = (i_ay <= i_py && i_py < i_by) || (i_by <= i_py && i_py < i_ay);

    // crossing lies strictly right of the point; compare direction follows dy
    assign w_cross = r2_dypos ? (r2_p2 < r2_p1) : (r2_p2 > r2_p1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r_edge <= 1'b0;
            r_par  <= 1'b0;
        end else begin
            r1_vld <= i_issue;
            r2_vld <= r1_vld;
            if (i_start) begin
                r_edge <= 1'b0;
                r_par  <= 1'b0;
            end else if (r2_vld) begin
                r_edge <= r_edge | (r2_box & (r2_p1 == r2_p2));
                r_par  <= r_par ^ (r2_strad & w_cross);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r1_dxab  <= DW'(i_bx) - DW'(i_ax);
        r1_dyp   <= DW'(i_py) - DW'(i_ay);
        r1_dxp   <= DW'(i_px) - DW'(i_ax);
        r1_dyab  <= DW'(i_by) - DW'(i_ay);
        r1_box   <= w_box;
        r1_strad <= w_strad;
        r1_dypos <= i_by > i_ay;

        r2_p1    <= PW'(r1_dxab) * PW'(r1_dyp);
        r2_p2    <= PW'(r1_dxp) * PW'(r1_dyab);
        r2_box   <= r1_box;
        r2_strad <= r1_strad;
        r2_dypos <= r1_dypos;
    end

    assign o_edge = r_edge;
    assign o_par  = r_par;

endmodule

/* src/point_in_polygon_test.sv */
// A query walks one full turn of the vertex ring, one edge per cycle through a
// three-stage evaluator, and then waits in a done state until the result
// register is free; a new query is not accepted until the block is idle again.
// Vertex writes are accepted only while idle. Reset clears control and sets
// vertex_count to 3; the ring holds garbage until written.
// ---------------------------------------------------------------------------
// point_in_polygon_test
// Crossing-number point-in-polygon tester over a ring of vertex cells.
// ---------------------------------------------------------------------------
`include "point_in_polygon_test_assert.svh"

module point_in_polygon_test
    import pip_pkg::*;
#(
    parameter int MAX_VERTICES = PIP_MAX_VERTICES,
    parameter int COORD_BITS   = PIP_COORD_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input channel
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_action,
    input  logic [PIP_SLOT_BITS-1:0]     i_slot,
    input  logic signed [COORD_BITS-1:0] i_coord_x,
    input  logic signed [COORD_BITS-1:0] i_coord_y,
    // result channel
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_inside_res,
    output logic                         o_on_edge,
    // configuration
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [PIP_CNT_BITS-1:0]      i_cfg_vertex_count
);

    localparam int LAST_STEP = MAX_VERTICES + 1;
    localparam int STEP_W    = $clog2(MAX_VERTICES + 2);
    localparam int CMP_W     = (STEP_W > PIP_CNT_BITS) ? STEP_W : PIP_CNT_BITS;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } t_state;

    t_state                       r_state;
    logic [STEP_W-1:0]            r_step;
    logic [PIP_CNT_BITS-1:0]      r_vcount;
    logic signed [COORD_BITS-1:0] r_px, r_py;
    logic signed [COORD_BITS-1:0] r_v0x, r_v0y;
    logic                         r_out_valid, r_inside, r_on_edge;

    logic signed [COORD_BITS-1:0] w_cx [MAX_VERTICES];
    logic signed [COORD_BITS-1:0] w_cy [MAX_VERTICES];

    logic              w_accept, w_write, w_query;
    logic              w_shift, w_issue, w_last, w_out_free;
    logic [CMP_W-1:0]  w_step_ext, w_n_eff;
    logic signed [COORD_BITS-1:0] w_bx, w_by;
    logic              w_edge, w_par;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_write     = w_accept && (i_action == PIP_ACT_WRITE);
    assign w_query     = w_accept && (i_action == PIP_ACT_QUERY);

    // effective vertex count, saturated at the ring size
    assign w_step_ext = CMP_W'(r_step);
    assign w_n_eff    = (CMP_W'(r_vcount) > CMP_W'(MAX_VERTICES)) ?
                        CMP_W'(MAX_VERTICES) : CMP_W'(r_vcount);

    assign w_shift = (r_state == ST_WALK) && (w_step_ext < CMP_W'(MAX_VERTICES));
    assign w_issue = (r_state == ST_WALK) && (w_step_ext < w_n_eff);
    assign w_last  = (w_step_ext + CMP_W'(1)) == w_n_eff;

    // closing edge goes back to vertex 0
    assign w_bx = w_last ? r_v0x : w_cx[1];
    assign w_by = w_last ? r_v0y : w_cy[1];

    // vertex ring: cell i holds vertex i at rest, takes cell i+1 while walking
    for (genvar gi = 0; gi < MAX_VERTICES; gi++) begin : g_cell
        t_cell_ctl w_ctl;

        assign w_ctl.shift = w_shift;
        assign w_ctl.load  = w_write && (32'(i_slot) == gi);

        pip_cell #(
            .COORD_BITS (COORD_BITS)
        ) u_cell (
            .i_clk    (i_clk),
            .i_ctl    (w_ctl),
            .i_load_x (i_coord_x),
            .i_load_y (i_coord_y),
            .i_next_x (w_cx[(gi + 1) % MAX_VERTICES]),
            .i_next_y (w_cy[(gi + 1) % MAX_VERTICES]),
            .o_x      (w_cx[gi]),
            .o_y      (w_cy[gi])
        );
    end

    pip_edge #(
        .COORD_BITS (COORD_BITS)
    ) u_edge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_query),
        .i_issue (w_issue),
        .i_ax    (w_cx[0]),
        .i_ay    (w_cy[0]),
        .i_bx    (w_bx),
        .i_by    (w_by),
        .i_px    (r_px),
        .i_py    (r_py),
        .o_edge  (w_edge),
        .o_par   (w_par)
    );

    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_vcount    <= PIP_VCOUNT_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_vcount <= i_cfg_vertex_count;
            end
            if (r_state == ST_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_query) begin
                        r_state <= ST_WALK;
                        r_step  <= '0;
                        r_px    <= i_coord_x;
                        r_py    <= i_coord_y;
                        r_v0x   <= w_cx[0];
                        r_v0y   <= w_cy[0];
                    end
                end
                ST_WALK: begin
                    // runs past the ring turn until the evaluator drains
                    if (r_step == STEP_W'(LAST_STEP)) begin
                        r_state <= ST_DONE;
                        r_step  <= '0;
                    end else begin
                        r_step <= r_step + STEP_W'(1);
                    end
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        r_inside    <= w_edge | w_par;
                        r_on_edge   <= w_edge;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_inside_res = r_inside;
    assign o_on_edge    = r_on_edge;

    `PIP_ASSERT_NXT(a_query_starts_walk, w_query, r_state == ST_WALK && r_step == '0)
    `PIP_ASSERT_IMP(a_ring_home_at_rest, r_state != ST_WALK, r_step == '0)
    `PIP_ASSERT_NXT(a_walk_ends_done, r_state == ST_WALK && r_step == STEP_W'(LAST_STEP), r_state == ST_DONE)
    `PIP_ASSERT_NXT(a_done_delivers, r_state == ST_DONE && w_out_free, r_out_valid && r_state == ST_IDLE)

endmodule

/* bench/point_in_polygon_test_tb.sv */
// ---------------------------------------------------------------------------
// point_in_polygon_test_tb
// Self-checking bench for the point-in-polygon tester. Vertex writes and
// point queries are sent over the input channel while the vertex count is
// moved between phases, from empty and degenerate polygons up to the
// saturated count. A scoreboard mirrors the vertex store, classifies every
// query with exact integer geometry and checks each result beat in order.
// ---------------------------------------------------------------------------
module point_in_polygon_test_tb;
    import pip_pkg::*;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = PIP_MAX_VERTICES + 16;
    localparam int STIM_BEATS    = 775;

    typedef logic signed [PIP_COORD_BITS-1:0] coord_t;
    typedef struct packed {
        logic in_poly;
        logic on_edge;
    } verdict_t;

    typedef enum int {SPREAD_TIGHT, SPREAD_MID, SPREAD_FULL, SPREAD_EXTREME} spread_t;
    typedef enum int {AIM_VERTEX, AIM_MIDPOINT, AIM_VERTEX_ROW, AIM_NEAR_VERTEX,
                      AIM_RANDOM} aim_t;

    localparam longint COORD_MAX = (longint'(1) <<< (PIP_COORD_BITS - 1)) - 1;
    localparam longint COORD_MIN = -COORD_MAX - 1;
    localparam coord_t XY_LOW    = coord_t'(COORD_MIN);
    localparam coord_t XY_HIGH   = coord_t'(COORD_MAX);

    // Mirrors the vertex store and holds the verdicts still owed by the block.
    class verdict_board;
        coord_t                  vx[PIP_MAX_VERTICES];
        coord_t                  vy[PIP_MAX_VERTICES];
        bit                      filled[PIP_MAX_VERTICES];
        logic [PIP_CNT_BITS-1:0] vcount;
        verdict_t                owed[$];
        int                      failures;
        int                      writes;
        int                      queries;
        int                      edge_hits;
        int                      inside_hits;
        int                      settings;

        function new();
            vcount = PIP_VCOUNT_RST;
        endfunction

        function int used_vertices();
            return (vcount > PIP_MAX_VERTICES) ? PIP_MAX_VERTICES : int'(vcount);
        endfunction

        function bit prefix_filled();
            int i;
            for (i = 0; i < used_vertices(); i++)
                if (!filled[i]) return 1'b0;
            return 1'b1;
        endfunction

        // closed segment a-b, exact collinearity plus bounding box
        function bit on_segment(input longint ax, ay, bx, by, px, py);
            if ((bx - ax) * (py - ay) != (px - ax) * (by - ay)) return 1'b0;
            return px >= ((ax < bx) ? ax : bx) && px <= ((ax > bx) ? ax : bx) &&
                   py >= ((ay < by) ? ay : by) && py <= ((ay > by) ? ay : by);
        endfunction

        function verdict_t classify(coord_t x, coord_t y);
            longint   px, py, xi, yi, xj, yj, dy, lhs, rhs;
            int       n, i, j;
            bit       touching, odd;
            verdict_t v;
            px = x;
            py = y;
            n = used_vertices();
            touching = 1'b0;
            odd = 1'b0;
            for (i = 0; i < n && !touching; i++) begin
                j = (i + 1 == n) ? 0 : i + 1;
                xi = vx[i]; yi = vy[i];
                xj = vx[j]; yj = vy[j];
                if (xi == px && yi == py)
                    touching = 1'b1;
                else if (on_segment(xi, yi, xj, yj, px, py))
                    touching = 1'b1;
            end
            // half-open ray crossing toward +x; division folded into the compare
            if (!touching) begin
                for (i = 0; i < n; i++) begin
                    j = (i == 0) ? n - 1 : i - 1;
                    xi = vx[i]; yi = vy[i];
                    xj = vx[j]; yj = vy[j];
                    if ((yi <= py && py < yj) || (yj <= py && py < yi)) begin
                        dy  = yj - yi;
                        lhs = (px - xi) * dy;
                        rhs = (xj - xi) * (py - yi);
                        if (dy > 0 ? lhs < rhs : lhs > rhs) odd = !odd;
                    end
                end
            end
            v.in_poly = touching || odd;
            v.on_edge = touching;
            return v;
        endfunction

        function void note_beat(logic act, logic [PIP_SLOT_BITS-1:0] slot, coord_t x,
                                coord_t y);
            verdict_t v;
            if (act == PIP_ACT_WRITE) begin
                vx[slot] = x;
                vy[slot] = y;
                filled[slot] = 1'b1;
                writes++;
            end else begin
                v = classify(x, y);
                owed = {owed, v};
                queries++;
                if (v.on_edge) edge_hits++;
                else if (v.in_poly) inside_hits++;
            end
        endfunction

        function void check_verdict(logic in_poly, logic on_edge);
            verdict_t v;
            if (owed.size() == 0) begin
                $error("result beat with no query outstanding: inside_res=%0b on_edge=%0b",
                       in_poly, on_edge);
                failures++;
                return;
            end
            v = owed.pop_front();
            if (in_poly !== v.in_poly) begin
                $error("inside_res: expected %0b, got %0b", v.in_poly, in_poly);
                failures++;
            end
            if (on_edge !== v.on_edge) begin
                $error("on_edge: expected %0b, got %0b", v.on_edge, on_edge);
                failures++;
            end
        endfunction
    endclass

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_ready;
    logic                      i_action = PIP_ACT_WRITE;
    logic [PIP_SLOT_BITS-1:0]  i_slot = '0;
    coord_t                    i_coord_x = '0;
    coord_t                    i_coord_y = '0;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    logic                      o_inside_res;
    logic                      o_on_edge;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [PIP_CNT_BITS-1:0]   i_cfg_vertex_count = '0;

    verdict_board sb;
    bit           steady = 1'b0;
    int           cycles = 0;

    point_in_polygon_test dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_action           (i_action),
        .i_slot             (i_slot),
        .i_coord_x          (i_coord_x),
        .i_coord_y          (i_coord_y),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_inside_res       (o_inside_res),
        .o_on_edge          (o_on_edge),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_vertex_count (i_cfg_vertex_count)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
    end

    // result side: check accepted beats, stall at random unless steady
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_verdict(o_inside_res, o_on_edge);
        i_out_ready <= steady || ($urandom_range(0, 99) >= 18);
    end

    initial begin
        wait (cycles >= CYCLE_LIMIT);
        $display("watchdog expired after %0d cycles", cycles);
        $display("point_in_polygon_test regression: fail");
        $finish;
    end

    function automatic coord_t to_coord(longint v);
        if (v > COORD_MAX) return XY_HIGH;
        if (v < COORD_MIN) return XY_LOW;
        return coord_t'(v);
    endfunction

    function automatic coord_t rand_coord(spread_t s);
        case (s)
            SPREAD_TIGHT: return to_coord(longint'($urandom_range(0, 16)) - 8);
            SPREAD_MID:   return to_coord(longint'($urandom_range(0, 2000)) - 1000);
            SPREAD_FULL:  return coord_t'($urandom());
            default: begin
                case ($urandom_range(0, 4))
                    0:       return XY_LOW;
                    1:       return XY_HIGH;
                    2:       return '0;
                    3:       return coord_t'(-1);
                    default: return coord_t'(1);
                endcase
            end
        endcase
    endfunction

    // query points aimed at vertices, edge midpoints, vertex rows and near vertices of the live polygon, or random
    function automatic void pick_point(int m, spread_t s, output coord_t x, output coord_t y);
        int   i, k;
        aim_t aim;
        if (m == 0) begin
            x = rand_coord(s);
            y = rand_coord(s);
            return;
        end
        i = $urandom_range(0, m - 1);
        k = (i + 1 == m) ? 0 : i + 1;
        aim = aim_t'($urandom_range(0, 4));
        case (aim)
            AIM_VERTEX: begin
                x = sb.vx[i];
                y = sb.vy[i];
            end
            AIM_MIDPOINT: begin
                x = to_coord((longint'(sb.vx[i]) + sb.vx[k]) >>> 1);
                y = to_coord((longint'(sb.vy[i]) + sb.vy[k]) >>> 1);
            end
            AIM_VERTEX_ROW: begin
                x = to_coord(longint'(sb.vx[i]) + longint'($urandom_range(0, 64)) - 32);
                y = sb.vy[i];
            end
            AIM_NEAR_VERTEX: begin
                x = to_coord(longint'(sb.vx[i]) + longint'($urandom_range(0, 2)) - 1);
                y = to_coord(longint'(sb.vy[i]) + longint'($urandom_range(0, 2)) - 1);
            end
            default: begin
                x = rand_coord(s);
                y = rand_coord(s);
            end
        endcase
    endfunction

    // valid stays high across back-to-back beats; this task only drops it for a gap
    task automatic send_beat(logic act, logic [PIP_SLOT_BITS-1:0] slot, coord_t x,
                             coord_t y);
        int gap;
        gap = 0;
        if (!steady) begin
            while ($urandom_range(0, 99) < 18) gap++;
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action   <= act;
        i_slot     <= slot;
        i_coord_x  <= x;
        i_coord_y  <= y;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_beat(act, slot, x, y);
    endtask

    task automatic send_query(coord_t x, coord_t y);
        send_beat(PIP_ACT_QUERY, PIP_SLOT_BITS'($urandom()), x, y);
    endtask

    // hold off the sender until every owed result is back, then let writes settle
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.owed.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_vertex_count(int n);
        drain();
        i_cfg_valid        <= 1'b1;
        i_cfg_vertex_count <= PIP_CNT_BITS'(n);
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.vcount = PIP_CNT_BITS'(n);
        sb.settings++;
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int      n, m, i, r;
        spread_t spread;
        int      phase;
        coord_t  qx, qy;

        sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // full-range triangle under the reset vertex count
        send_beat(PIP_ACT_WRITE, PIP_SLOT_BITS'(0), XY_LOW, XY_LOW);
        send_beat(PIP_ACT_WRITE, PIP_SLOT_BITS'(1), XY_HIGH, XY_LOW);
        send_beat(PIP_ACT_WRITE, PIP_SLOT_BITS'(2), '0, XY_HIGH);
        send_query(XY_LOW, XY_LOW);
        send_query('0, XY_LOW);
        send_query('0, '0);
        send_query(XY_HIGH, XY_HIGH);
        send_query(XY_LOW, XY_HIGH);
        send_query(16'sd16384, '0);
        send_query(16'sd16383, '0);
        send_query(XY_HIGH, -16'sd32767);
        // empty polygon
        set_vertex_count(0);
        send_query('0, '0);
        send_query(XY_LOW, XY_LOW);
        // single vertex, then a lone segment
        set_vertex_count(1);
        send_query(XY_LOW, XY_LOW);
        send_query('0, '0);
        set_vertex_count(2);
        send_query('0, XY_LOW);
        send_query(16'sd5, 16'sd5);
        // repeated vertex gives a zero-length edge
        send_beat(PIP_ACT_WRITE, PIP_SLOT_BITS'(2), XY_HIGH, XY_LOW);
        set_vertex_count(3);
        send_query(XY_HIGH, XY_LOW);
        send_query(16'sd7, XY_LOW);
        send_query(16'sd7, -16'sd32767);

        phase = 0;
        while (sb.writes + sb.queries < STIM_BEATS) begin
            r = $urandom_range(0, 99);
            if (r < 12)      n = $urandom_range(0, 2);
            else if (r < 20) n = PIP_MAX_VERTICES;
            else if (r < 24) n = (1 << PIP_CNT_BITS) - 1;
            else if (r < 28) n = $urandom_range(PIP_MAX_VERTICES + 1, (1 << PIP_CNT_BITS) - 2);
            else if (r < 40) n = $urandom_range(13, PIP_MAX_VERTICES - 1);
            else             n = $urandom_range(3, 12);
            m = (n > PIP_MAX_VERTICES) ? PIP_MAX_VERTICES : n;
            spread = spread_t'($urandom_range(0, 3));
            set_vertex_count(n);
            steady = (phase == 2);

            for (i = 0; i < m; i++) begin
                send_beat(PIP_ACT_WRITE, PIP_SLOT_BITS'(i), rand_coord(spread),
                          rand_coord(spread));
                // stray beats in the middle of loading the polygon
                if ($urandom_range(0, 99) < 8) begin
                    if ($urandom_range(0, 1) || !sb.prefix_filled()) begin
                        send_beat(PIP_ACT_WRITE, PIP_SLOT_BITS'($urandom()),
                                  rand_coord(SPREAD_FULL), rand_coord(SPREAD_FULL));
                    end else begin
                        pick_point(m, spread, qx, qy);
                        send_query(qx, qy);
                    end
                end
            end

            repeat ($urandom_range(6, 20)) begin
                if ($urandom_range(0, 99) < 10) begin
                    send_beat(PIP_ACT_WRITE, PIP_SLOT_BITS'($urandom_range(0, m)),
                              rand_coord(spread), rand_coord(spread));
                end else begin
                    pick_point(m, spread, qx, qy);
                    send_query(qx, qy);
                end
            end
            steady = 1'b0;
            phase++;
        end

        drain();

        $display("Ran %0d vertex writes and %0d point queries over %0d vertex-count settings.",
                 sb.writes, sb.queries, sb.settings + 1);
        $display("Queries landed %0d times on the boundary and %0d times strictly inside.",
                 sb.edge_hits, sb.inside_hits);
        if (sb.failures == 0)
            $display("point_in_polygon_test regression: pass");
        else
            $display("point_in_polygon_test regression: fail");
        $finish;
    end

endmodule

/* files.f */
+incdir+src
src/pip_pkg.sv
src/pip_cell.sv
src/pip_edge.sv
src/point_in_polygon_test.sv
bench/point_in_polygon_test_tb.sv
